// File: rtl/oled_text_cursor_renderer_core_macros.svh
// Assertion macros shared by the text renderer RTL.
// Included by otcr_emitter, which carries concurrent checks; needs clk and rst_n in scope.
`ifndef OLED_TEXT_CURSOR_RENDERER_CORE_MACROS_SVH
`define OLED_TEXT_CURSOR_RENDERER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define OTCR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define OTCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/otcr_pkg.sv
// Shared types, constants and the 5x8 font table for the text renderer.
// No dependencies; used by otcr_decode, otcr_emitter and the top level.
`default_nettype none

package otcr_pkg;

  // Fixed glyph geometry.
  localparam int GLYPH_COLUMNS = 5;

  // Request kinds.
  localparam logic KIND_PRINT      = 1'b0;
  localparam logic KIND_SET_CURSOR = 1'b1;

  // Command and character codes.
  localparam logic [7:0] CMD_COLUMN_RANGE = 8'h21;
  localparam logic [7:0] CMD_PAGE_RANGE   = 8'h22;
  localparam logic [7:0] FIRST_GLYPH      = 8'h20;
  localparam logic [7:0] LAST_GLYPH       = 8'h7E;
  localparam logic [7:0] NEWLINE          = 8'h0A;
  localparam logic [7:0] BLANK_COLUMN     = 8'h00;

  // Transfer flag: command or data.
  localparam logic XFER_COMMAND = 1'b0;
  localparam logic XFER_DATA    = 1'b1;

  // Five font columns, column 0 in the most significant byte.
  typedef logic [0:GLYPH_COLUMNS-1][7:0] glyph_t;

  // Work handed from the decoder to the emitter for one request.
  typedef struct packed {
    logic       emit_cursor;
    logic       emit_glyph;
    logic [2:0] line;
    logic [7:0] column;
    glyph_t     glyph;
  } plan_t;

  // Font table; codes without a glyph come back blank.
  function automatic glyph_t glyph_rom(input logic [7:0] code);
    glyph_t g;
    unique case (code)
      8'h20: g = 40'h00_00_00_00_00;
      8'h21: g = 40'h00_00_2F_00_00;
      8'h22: g = 40'h00_07_00_07_00;
      8'h23: g = 40'h14_7F_14_7F_14;
      8'h24: g = 40'h24_2A_7F_2A_12;
      8'h25: g = 40'h23_13_08_64_62;
      8'h26: g = 40'h36_49_55_22_50;
      8'h27: g = 40'h00_05_03_00_00;
      8'h28: g = 40'h00_1C_22_41_00;
      8'h29: g = 40'h00_41_22_1C_00;
      8'h2A: g = 40'h14_08_3E_08_14;
      8'h2B: g = 40'h08_08_3E_08_08;
      8'h2C: g = 40'h00_00_A0_60_00;
      8'h2D: g = 40'h08_08_08_08_08;
      8'h2E: g = 40'h00_60_60_00_00;
      8'h2F: g = 40'h20_10_08_04_02;
      8'h30: g = 40'h3E_51_49_45_3E;
      8'h31: g = 40'h00_42_7F_40_00;
      8'h32: g = 40'h42_61_51_49_46;
      8'h33: g = 40'h21_41_45_4B_31;
      8'h34: g = 40'h18_14_12_7F_10;
      8'h35: g = 40'h27_45_45_45_39;
      8'h36: g = 40'h3C_4A_49_49_30;
      8'h37: g = 40'h01_71_09_05_03;
      8'h38: g = 40'h36_49_49_49_36;
      8'h39: g = 40'h06_49_49_29_1E;
      8'h3A: g = 40'h00_36_36_00_00;
      8'h3B: g = 40'h00_56_36_00_00;
      8'h3C: g = 40'h08_14_22_41_00;
      8'h3D: g = 40'h14_14_14_14_14;
      8'h3E: g = 40'h00_41_22_14_08;
      8'h3F: g = 40'h02_01_51_09_06;
      8'h40: g = 40'h32_49_59_51_3E;
      8'h41: g = 40'h7C_12_11_12_7C;
      8'h42: g = 40'h7F_49_49_49_36;
      8'h43: g = 40'h3E_41_41_41_22;
      8'h44: g = 40'h7F_41_41_22_1C;
      8'h45: g = 40'h7F_49_49_49_41;
      8'h46: g = 40'h7F_09_09_09_01;
      8'h47: g = 40'h3E_41_49_49_7A;
      8'h48: g = 40'h7F_08_08_08_7F;
      8'h49: g = 40'h00_41_7F_41_00;
      8'h4A: g = 40'h20_40_41_3F_01;
      8'h4B: g = 40'h7F_08_14_22_41;
      8'h4C: g = 40'h7F_40_40_40_40;
      8'h4D: g = 40'h7F_02_0C_02_7F;
      8'h4E: g = 40'h7F_04_08_10_7F;
      8'h4F: g = 40'h3E_41_41_41_3E;
      8'h50: g = 40'h7F_09_09_09_06;
      8'h51: g = 40'h3E_41_51_21_5E;
      8'h52: g = 40'h7F_09_19_29_46;
      8'h53: g = 40'h46_49_49_49_31;
      8'h54: g = 40'h01_01_7F_01_01;
      8'h55: g = 40'h3F_40_40_40_3F;
      8'h56: g = 40'h1F_20_40_20_1F;
      8'h57: g = 40'h3F_40_38_40_3F;
      8'h58: g = 40'h63_14_08_14_63;
      8'h59: g = 40'h07_08_70_08_07;
      8'h5A: g = 40'h61_51_49_45_43;
      8'h5B: g = 40'h00_7F_41_41_00;
      8'h5C: g = 40'h55_AA_55_AA_55;
      8'h5D: g = 40'h00_41_41_7F_00;
      8'h5E: g = 40'h04_02_01_02_04;
      8'h5F: g = 40'h40_40_40_40_40;
      8'h60: g = 40'h00_03_05_00_00;
      8'h61: g = 40'h20_54_54_54_78;
      8'h62: g = 40'h7F_48_44_44_38;
      8'h63: g = 40'h38_44_44_44_20;
      8'h64: g = 40'h38_44_44_48_7F;
      8'h65: g = 40'h38_54_54_54_18;
      8'h66: g = 40'h08_7E_09_01_02;
      8'h67: g = 40'h18_A4_A4_A4_7C;
      8'h68: g = 40'h7F_08_04_04_78;
      8'h69: g = 40'h00_44_7D_40_00;
      8'h6A: g = 40'h40_80_84_7D_00;
      8'h6B: g = 40'h7F_10_28_44_00;
      8'h6C: g = 40'h00_41_7F_40_00;
      8'h6D: g = 40'h7C_04_18_04_78;
      8'h6E: g = 40'h7C_08_04_04_78;
      8'h6F: g = 40'h38_44_44_44_38;
      8'h70: g = 40'hFC_24_24_24_18;
      8'h71: g = 40'h18_24_24_18_FC;
      8'h72: g = 40'h7C_08_04_04_08;
      8'h73: g = 40'h48_54_54_54_20;
      8'h74: g = 40'h04_3F_44_40_20;
      8'h75: g = 40'h3C_40_40_20_7C;
      8'h76: g = 40'h1C_20_40_20_1C;
      8'h77: g = 40'h3C_40_30_40_3C;
      8'h78: g = 40'h44_28_10_28_44;
      8'h79: g = 40'h1C_A0_A0_A0_7C;
      8'h7A: g = 40'h44_64_54_4C_44;
      8'h7B: g = 40'h00_10_7C_82_00;
      8'h7C: g = 40'h00_00_FF_00_00;
      8'h7D: g = 40'h00_82_7C_10_00;
      8'h7E: g = 40'h00_06_09_09_06;
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// File: rtl/otcr_decode.sv
// Request decoder: holds the cursor and turns one request into a plan of transfers.
// Depends on otcr_pkg.
`default_nettype none

module otcr_decode #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           accept,
  input  wire logic           kind,
  input  wire logic [7:0]     char_code,
  input  wire logic [7:0]     line,
  input  wire logic [7:0]     column,
  output otcr_pkg::plan_t     plan,
  output logic                has_results
);

  logic [2:0] cursor_line_r;
  logic [2:0] cursor_line_nxt;
  logic [7:0] cursor_column_r;
  logic [7:0] cursor_column_nxt;

  logic       is_newline;
  logic       wrap;
  logic [2:0] wrap_line;
  logic [2:0] pos_line;
  logic [7:0] pos_column;
  logic       set_ok;

  // Print path: decide on a line break and where the glyph lands.
  assign is_newline = (char_code == otcr_pkg::NEWLINE);
  assign wrap = (({1'b0, cursor_column_r} + 9'(otcr_pkg::GLYPH_COLUMNS)) >= 9'(COLUMNS))
                || is_newline;
  assign wrap_line = (({1'b0, cursor_line_r} + 4'd1) >= 4'(PAGES)) ? 3'd0
                     : cursor_line_r + 3'd1;
  assign pos_line   = wrap ? wrap_line : cursor_line_r;
  assign pos_column = wrap ? 8'd0 : cursor_column_r;

  // Set-cursor path: only a position on the panel is taken.
  assign set_ok = (line < 8'(PAGES)) && (column < 8'(COLUMNS));

  // Plan and next cursor for the request at the input.
  always_comb begin
    plan.glyph        = otcr_pkg::glyph_rom(char_code);
    cursor_line_nxt   = cursor_line_r;
    cursor_column_nxt = cursor_column_r;
    if (kind == otcr_pkg::KIND_SET_CURSOR) begin
      plan.emit_cursor = set_ok;
      plan.emit_glyph  = 1'b0;
      plan.line        = line[2:0];
      plan.column      = column;
      if (set_ok) begin
        cursor_line_nxt   = line[2:0];
        cursor_column_nxt = column;
      end
    end else begin
      plan.emit_cursor  = wrap;
      plan.emit_glyph   = !is_newline;
      plan.line         = pos_line;
      plan.column       = pos_column;
      cursor_line_nxt   = pos_line;
      cursor_column_nxt = is_newline ? pos_column
                          : pos_column + 8'(otcr_pkg::GLYPH_COLUMNS + 1);
    end
  end

  assign has_results = plan.emit_cursor | plan.emit_glyph;

  // Cursor state moves when a request is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_line_r   <= 3'd0;
      cursor_column_r <= 8'd0;
    end else if (accept) begin
      cursor_line_r   <= cursor_line_nxt;
      cursor_column_r <= cursor_column_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/otcr_emitter.sv
// Transfer sequencer: walks a plan one transfer per cycle into the output register while it is not stalled.
// Depends on otcr_pkg and oled_text_cursor_renderer_core_macros.svh.
`default_nettype none

`include "oled_text_cursor_renderer_core_macros.svh"

module otcr_emitter #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            load_req,
  input  wire otcr_pkg::plan_t plan_in,
  output logic                 ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_is_data,
  output logic                 out_last
);

  // Position within the twelve-transfer sequence.
  typedef enum logic [3:0] {
    BEAT_COL_CMD,
    BEAT_COL_START,
    BEAT_COL_END,
    BEAT_PAGE_CMD,
    BEAT_PAGE_START,
    BEAT_PAGE_END,
    BEAT_GLYPH0,
    BEAT_GLYPH1,
    BEAT_GLYPH2,
    BEAT_GLYPH3,
    BEAT_GLYPH4,
    BEAT_SPACER
  } beat_t;

  otcr_pkg::plan_t plan_r;
  logic            plan_valid_r;
  beat_t           beat_r;
  beat_t           end_beat;
  logic            out_valid_r;
  logic [7:0]      out_byte_r;
  logic            out_is_data_r;
  logic            out_last_r;

  logic            out_free;
  logic            fire;
  logic            last_beat;
  logic            done;
  logic            load;
  logic [7:0]      beat_byte;
  logic            beat_is_data;

  // Handshake between plan register and output register.
  assign end_beat  = plan_r.emit_glyph ? BEAT_SPACER : BEAT_PAGE_END;
  assign out_free  = !out_valid_r || out_ready;
  assign fire      = plan_valid_r && out_free;
  assign last_beat = (beat_r == end_beat);
  assign done      = fire && last_beat;
  assign ready     = !plan_valid_r || done;
  assign load      = ready && load_req;

  // Byte and flag for the current transfer.
  always_comb begin
    beat_is_data = otcr_pkg::XFER_DATA;
    unique case (beat_r)
      BEAT_COL_CMD: begin
        beat_byte    = otcr_pkg::CMD_COLUMN_RANGE;
        beat_is_data = otcr_pkg::XFER_COMMAND;
      end
      BEAT_COL_START: begin
        beat_byte    = plan_r.column;
        beat_is_data = otcr_pkg::XFER_COMMAND;
      end
      BEAT_COL_END: begin
        beat_byte    = 8'(COLUMNS - 1);
        beat_is_data = otcr_pkg::XFER_COMMAND;
      end
      BEAT_PAGE_CMD: begin
        beat_byte    = otcr_pkg::CMD_PAGE_RANGE;
        beat_is_data = otcr_pkg::XFER_COMMAND;
      end
      BEAT_PAGE_START: begin
        beat_byte    = {5'd0, plan_r.line};
        beat_is_data = otcr_pkg::XFER_COMMAND;
      end
      BEAT_PAGE_END: begin
        beat_byte    = 8'(PAGES - 1);
        beat_is_data = otcr_pkg::XFER_COMMAND;
      end
      BEAT_GLYPH0: beat_byte = plan_r.glyph[0];
      BEAT_GLYPH1: beat_byte = plan_r.glyph[1];
      BEAT_GLYPH2: beat_byte = plan_r.glyph[2];
      BEAT_GLYPH3: beat_byte = plan_r.glyph[3];
      BEAT_GLYPH4: beat_byte = plan_r.glyph[4];
      BEAT_SPACER: beat_byte = otcr_pkg::BLANK_COLUMN;
      default:     beat_byte = otcr_pkg::BLANK_COLUMN;
    endcase
  end

  // Plan register and sequence position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plan_valid_r <= 1'b0;
      beat_r       <= BEAT_COL_CMD;
    end else if (load) begin
      plan_valid_r <= 1'b1;
      beat_r       <= plan_in.emit_cursor ? BEAT_COL_CMD : BEAT_GLYPH0;
    end else if (done) begin
      plan_valid_r <= 1'b0;
    end else if (fire) begin
      beat_r <= beat_t'(beat_r + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      plan_r <= plan_in;
    end
  end

  // Output register: valid is control, payload needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte_r    <= beat_byte;
      out_is_data_r <= beat_is_data;
      out_last_r    <= last_beat;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_byte    = out_byte_r;
  assign out_is_data = out_is_data_r;
  assign out_last    = out_last_r;

  // The sequence never runs past the end of its plan.
  `OTCR_ASSERT_IMP(a_beat_in_plan, plan_valid_r, beat_r <= end_beat, "beat past end of plan")
  // A stored plan always carries a page on the panel.
  `OTCR_ASSERT_IMP(a_line_in_range, plan_valid_r, 4'(plan_r.line) < 4'(PAGES), "page out of range")
  // The final transfer of a plan shows up flagged as last.
  `OTCR_ASSERT_NEXT(a_last_marked, done, out_valid_r && out_last_r, "last transfer not marked")
  // A taken plan shows up as valid in the plan register.
  `OTCR_ASSERT_NEXT(a_plan_loaded, load, plan_valid_r, "plan not loaded")

endmodule

`default_nettype wire

// File: rtl/oled_text_cursor_renderer_core.sv
// Text renderer: a print or set-cursor request gives up to twelve bus transfers.
// One transfer per cycle from the output register while out_tready is high; a print gives
// 6 or 12 transfers, a set-cursor 6 and an out-of-range set-cursor none; a new request
// is taken as the previous one's last transfer leaves the sequencer. Synchronous
// active-low reset puts the cursor at page 0, column 0 and empties the sequencer and
// output register.
`default_nettype none

module oled_text_cursor_renderer_core #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // char_code[7:0], line[15:8], column[23:16]
  input  wire logic        in_tuser,   // kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // out_byte[7:0]
  output logic             out_tuser,  // is_data
  output logic             out_tlast
);

  otcr_pkg::plan_t plan;
  logic            has_results;
  logic            accept;

  // A request is taken on a completed handshake.
  assign accept = in_tvalid && in_tready;

  otcr_decode #(
    .COLUMNS(COLUMNS),
    .PAGES  (PAGES)
  ) u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .kind       (in_tuser),
    .char_code  (in_tdata[7:0]),
    .line       (in_tdata[15:8]),
    .column     (in_tdata[23:16]),
    .plan       (plan),
    .has_results(has_results)
  );

  otcr_emitter #(
    .COLUMNS(COLUMNS),
    .PAGES  (PAGES)
  ) u_emitter (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_req   (accept && has_results),
    .plan_in    (plan),
    .ready      (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (out_tdata),
    .out_is_data(out_tuser),
    .out_last   (out_tlast)
  );

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for the OLED text renderer: prints, newlines and cursor moves.
// Needs otcr_pkg and oled_text_cursor_renderer_core; a built-in predictor checks each transfer.
`default_nettype none

module tb_top;

  localparam int COLUMNS     = 128;
  localparam int PAGES       = 8;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_REQS = 157;

  // One bus transfer as seen on the result channel.
  typedef struct packed {
    logic       is_data;
    logic [7:0] xfer_byte;
    logic       last;
  } transfer_t;

  // Predicts the transfer stream from the cursor state and checks what the block sends.
  class cursor_text_predictor;
    logic [2:0]  cur_line;
    logic [7:0]  cur_column;
    logic [39:0] font_rows [95];
    transfer_t   pending [$];
    int          mismatches;
    int          requests_taken;
    int          cursor_moves;
    int          ignored;
    int          transfers_seen;

    function new();
      cur_line   = '0;
      cur_column = '0;
      mismatches = 0;
      requests_taken = 0;
      cursor_moves = 0;
      ignored = 0;
      transfers_seen = 0;
      // Font for codes 0x20 to 0x7E, first column in the top byte.
      font_rows = '{
        40'h0000000000, 40'h00002F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
        40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
        40'h14083E0814, 40'h08083E0808, 40'h0000A06000, 40'h0808080808, 40'h0060600000,
        40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
        40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
        40'h0041221408, 40'h0201510906, 40'h324959513E, 40'h7C1211127C, 40'h7F49494936,
        40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
        40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
        40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
        40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
        40'h55AA55AA55, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0003050000,
        40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
        40'h087E090102, 40'h18A4A4A47C, 40'h7F08040478, 40'h00447D4000, 40'h4080847D00,
        40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'hFC24242418, 40'h18242418FC, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
        40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h1CA0A0A07C,
        40'h4464544C44, 40'h00107C8200, 40'h0000FF0000, 40'h00827C1000, 40'h0006090906
      };
    endfunction

    // The six commands that set the column and page windows from the cursor.
    function void push_cursor_window(ref transfer_t burst [$]);
      burst.push_back('{otcr_pkg::XFER_COMMAND, otcr_pkg::CMD_COLUMN_RANGE, 1'b0});
      burst.push_back('{otcr_pkg::XFER_COMMAND, cur_column, 1'b0});
      burst.push_back('{otcr_pkg::XFER_COMMAND, 8'(COLUMNS - 1), 1'b0});
      burst.push_back('{otcr_pkg::XFER_COMMAND, otcr_pkg::CMD_PAGE_RANGE, 1'b0});
      burst.push_back('{otcr_pkg::XFER_COMMAND, {5'b0, cur_line}, 1'b0});
      burst.push_back('{otcr_pkg::XFER_COMMAND, 8'(PAGES - 1), 1'b0});
    endfunction

    // Work out the transfers for one accepted request and update the cursor.
    function void note_request(logic kind, logic [7:0] code, logic [7:0] line,
                               logic [7:0] column);
      transfer_t   burst [$];
      logic [39:0] glyph;
      logic        printable;
      requests_taken++;
      if (kind == otcr_pkg::KIND_SET_CURSOR) begin
        if (line < PAGES && column < COLUMNS) begin
          cur_line   = line[2:0];
          cur_column = column;
          cursor_moves++;
          push_cursor_window(burst);
        end else begin
          ignored++;
        end
      end else begin
        // Wrap to the next page on newline or when the glyph would reach the edge.
        if (int'(cur_column) + otcr_pkg::GLYPH_COLUMNS >= COLUMNS
            || code == otcr_pkg::NEWLINE) begin
          cur_line   = (int'(cur_line) + 1 >= PAGES) ? 3'd0 : cur_line + 3'd1;
          cur_column = '0;
          push_cursor_window(burst);
        end
        if (code != otcr_pkg::NEWLINE) begin
          printable = (code >= otcr_pkg::FIRST_GLYPH && code <= otcr_pkg::LAST_GLYPH);
          glyph = printable ? font_rows[code - otcr_pkg::FIRST_GLYPH] : '0;
          for (int k = 0; k < otcr_pkg::GLYPH_COLUMNS; k++)
            burst.push_back('{otcr_pkg::XFER_DATA, glyph[39 - 8 * k -: 8], 1'b0});
          burst.push_back('{otcr_pkg::XFER_DATA, otcr_pkg::BLANK_COLUMN, 1'b0});
          cur_column = cur_column + 8'(otcr_pkg::GLYPH_COLUMNS + 1);
        end
      end
      if (burst.size() > 0)
        burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i])
        pending.push_back(burst[i]);
    endfunction

    // Compare one transfer from the block with the oldest expectation.
    function void check_transfer(logic is_data, logic [7:0] xfer_byte, logic last);
      transfer_t want;
      transfers_seen++;
      if (pending.size() == 0) begin
        $error("unexpected transfer: is_data %0b, byte 0x%02h, last %0b",
               is_data, xfer_byte, last);
        mismatches++;
      end else begin
        want = pending.pop_front();
        if (is_data !== want.is_data) begin
          $error("is_data: expected %0b, got %0b", want.is_data, is_data);
          mismatches++;
        end
        if (xfer_byte !== want.xfer_byte) begin
          $error("out_byte: expected 0x%02h, got 0x%02h", want.xfer_byte, xfer_byte);
          mismatches++;
        end
        if (last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tuser = otcr_pkg::KIND_PRINT;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  cursor_text_predictor model;
  bit  no_idle = 1'b0;
  int  ready_hold = 0;
  int  cycle_count = 0;

  oled_text_cursor_renderer_core #(
    .COLUMNS(COLUMNS),
    .PAGES  (PAGES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // Clock with a 12-unit period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Offer one request after an optional gap and hold it until it is taken.
  task automatic send_request(logic kind, logic [7:0] code, logic [7:0] line,
                              logic [7:0] column);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {column, line, code};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    model.note_request(kind, code, line, column);
  endtask

  // Result side: check each accepted transfer and stall the consumer at random.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      model.check_transfer(out_tuser, out_tdata, out_tlast);
    if (rst_n && ready_hold == 0 && $urandom_range(0, 2) == 0)
      ready_hold = idle_gap();
    out_tready <= (ready_hold == 0);
    if (ready_hold > 0)
      ready_hold--;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d transfers outstanding",
               cycle_count, model.pending.size());
      $display("oled_text_cursor_renderer_core test failed");
      $finish;
    end
  end

  // Stimulus: directed corner cases, then a random mix of requests.
  initial begin
    int         counted;
    int         r;
    logic       kind;
    logic [7:0] code;
    logic [7:0] line;
    logic [7:0] column;
    model = new();
    counted = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Glyph edges, codes with no glyph and a newline.
    send_request(otcr_pkg::KIND_PRINT, 8'h41, 8'h00, 8'h00);
    send_request(otcr_pkg::KIND_PRINT, otcr_pkg::FIRST_GLYPH, 8'hFF, 8'hFF);
    send_request(otcr_pkg::KIND_PRINT, otcr_pkg::LAST_GLYPH, 8'h00, 8'h00);
    send_request(otcr_pkg::KIND_PRINT, 8'h7F, 8'h00, 8'h00);
    send_request(otcr_pkg::KIND_PRINT, 8'h1F, 8'h00, 8'h00);
    send_request(otcr_pkg::KIND_PRINT, 8'h00, 8'h00, 8'h00);
    send_request(otcr_pkg::KIND_PRINT, 8'hFF, 8'h00, 8'h00);
    send_request(otcr_pkg::KIND_PRINT, otcr_pkg::NEWLINE, 8'h00, 8'h00);
    // Cursor at the last page and column, so the next glyph wraps to page 0.
    send_request(otcr_pkg::KIND_SET_CURSOR, 8'hFF, 8'd7, 8'd127);
    send_request(otcr_pkg::KIND_PRINT, 8'h5C, 8'h00, 8'h00);
    // Out-of-range cursor moves are dropped.
    send_request(otcr_pkg::KIND_SET_CURSOR, 8'h00, 8'd8, 8'd0);
    send_request(otcr_pkg::KIND_SET_CURSOR, 8'h00, 8'd0, 8'd128);
    send_request(otcr_pkg::KIND_SET_CURSOR, 8'hFF, 8'd255, 8'd255);
    // A glyph that just fits, then one that must wrap.
    send_request(otcr_pkg::KIND_SET_CURSOR, 8'h00, 8'd7, 8'd122);
    send_request(otcr_pkg::KIND_PRINT, 8'h7C, 8'h00, 8'h00);
    send_request(otcr_pkg::KIND_PRINT, 8'h30, 8'h00, 8'h00);
    send_request(otcr_pkg::KIND_SET_CURSOR, 8'h00, 8'd7, 8'd123);
    send_request(otcr_pkg::KIND_PRINT, 8'h21, 8'h00, 8'h00);
    // Newline on the last page wraps the page.
    send_request(otcr_pkg::KIND_SET_CURSOR, 8'h00, 8'd7, 8'd0);
    send_request(otcr_pkg::KIND_PRINT, otcr_pkg::NEWLINE, 8'hFF, 8'hFF);
    send_request(otcr_pkg::KIND_SET_CURSOR, otcr_pkg::NEWLINE, 8'd0, 8'd0);
    send_request(otcr_pkg::KIND_PRINT, 8'h61, 8'hFF, 8'hFF);
    send_request(otcr_pkg::KIND_PRINT, otcr_pkg::NEWLINE, 8'h00, 8'h00);

    // Random mix of prints, newlines and cursor moves, in and out of range.
    while (counted < RANDOM_REQS) begin
      if (counted % 45 == 0)
        no_idle = ($urandom_range(0, 2) == 0);
      r      = $urandom_range(0, 99);
      code   = 8'($urandom_range(0, 255));
      line   = 8'($urandom_range(0, 255));
      column = 8'($urandom_range(0, 255));
      if (r < 55) begin
        kind = otcr_pkg::KIND_PRINT;
        code = 8'($urandom_range(otcr_pkg::FIRST_GLYPH, otcr_pkg::LAST_GLYPH));
      end else if (r < 63) begin
        kind = otcr_pkg::KIND_PRINT;
        code = otcr_pkg::NEWLINE;
      end else if (r < 73) begin
        kind = otcr_pkg::KIND_PRINT;
        while ((code >= otcr_pkg::FIRST_GLYPH && code <= otcr_pkg::LAST_GLYPH)
               || code == otcr_pkg::NEWLINE)
          code = 8'($urandom_range(0, 255));
      end else if (r < 88) begin
        kind = otcr_pkg::KIND_SET_CURSOR;
        line = 8'($urandom_range(0, PAGES - 1));
        column = $urandom_range(0, 1) ? 8'($urandom_range(0, COLUMNS - 1))
                                      : 8'($urandom_range(COLUMNS - 18, COLUMNS - 1));
      end else begin
        kind = otcr_pkg::KIND_SET_CURSOR;
        if ($urandom_range(0, 1))
          line = 8'($urandom_range(PAGES, 255));
        else
          column = 8'($urandom_range(COLUMNS, 255));
      end
      send_request(kind, code, line, column);
      counted++;
    end
    in_tvalid <= 1'b0;
    no_idle = 1'b0;

    // Drain, then give the block time to show any stray transfer.
    while (model.pending.size() != 0)
      @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Covered %0d requests (%0d cursor moves, %0d ignored) and %0d transfers,",
             model.requests_taken, model.cursor_moves, model.ignored, model.transfers_seen);
    $display("with random gaps and stalls on both sides; %0d mismatches.", model.mismatches);
    if (model.mismatches == 0) begin
      $display("oled_text_cursor_renderer_core test passed");
    end else begin
      $display("oled_text_cursor_renderer_core test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
+incdir+rtl
rtl/otcr_pkg.sv
rtl/otcr_decode.sv
rtl/otcr_emitter.sv
rtl/oled_text_cursor_renderer_core.sv
bench/tb_top.sv
